// ===== sv/sha1bc_pkg.sv =====
`timescale 1ns / 1ps

package sha1bc_pkg;

   localparam int unsigned WORD_BITS       = 32;
   localparam int unsigned WORDS_PER_BLOCK = 16;
   localparam int unsigned CHAIN_WORDS     = 5;
   localparam int unsigned ROUNDS          = 80;
   localparam int unsigned POS_BITS        = $clog2(WORDS_PER_BLOCK);
   localparam int unsigned ROUND_BITS      = $clog2(ROUNDS);

   typedef logic [WORD_BITS-1:0]  word_type;
   typedef logic [POS_BITS-1:0]   pos_type;
   typedef logic [ROUND_BITS-1:0] round_count_type;

   localparam pos_type         LAST_POS   = pos_type'(WORDS_PER_BLOCK - 1);
   localparam round_count_type LAST_ROUND = round_count_type'(ROUNDS - 1);

   // standard initial chaining values
   localparam word_type INIT_VALUES [CHAIN_WORDS] = '{
      32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
   };

   // per-phase round constants
   localparam word_type K_CH     = 32'h5A82_7999;
   localparam word_type K_PAR_LO = 32'h6ED9_EBA1;
   localparam word_type K_MAJ    = 32'h8F1B_BCDC;
   localparam word_type K_PAR_HI = 32'hCA62_C1D6;

   typedef enum logic [1:0] {
      PH_CH,
      PH_PAR_LO,
      PH_MAJ,
      PH_PAR_HI
   } phase_type;

   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_ROUND,
      ST_FINAL
   } state_type;

   typedef struct packed {
      word_type message_word;
      logic     start_message;
   } req_type;

   typedef struct packed {
      word_type digest_a;
      word_type digest_b;
      word_type digest_c;
      word_type digest_d;
      word_type digest_e;
   } rsp_type;

   typedef struct packed {
      logic      load_init;
      logic      load_work;
      logic      round_en;
      logic      feed_fwd;
      phase_type phase;
   } round_ctrl_type;

   typedef struct packed {
      logic shift_in;
      logic expand;
   } sched_ctrl_type;

   // round function group of a round number
   function automatic phase_type round_phase(round_count_type count);
      phase_type ph;
      priority if (count < round_count_type'(20)) begin
         ph = PH_CH;
      end else if (count < round_count_type'(40)) begin
         ph = PH_PAR_LO;
      end else if (count < round_count_type'(60)) begin
         ph = PH_MAJ;
      end else begin
         ph = PH_PAR_HI;
      end
      return ph;
   endfunction

   function automatic word_type round_const(phase_type ph);
      word_type k;
      unique case (ph)
         PH_CH:     k = K_CH;
         PH_PAR_LO: k = K_PAR_LO;
         PH_MAJ:    k = K_MAJ;
         PH_PAR_HI: k = K_PAR_HI;
         default:   k = K_CH;
      endcase
      return k;
   endfunction

endpackage

// ===== sv/sha1bc_schedule.sv =====
`timescale 1ns / 1ps

module sha1bc_schedule (
   input  logic                     clock,
   input  sha1bc_pkg::sched_ctrl_type ctrl,
   input  sha1bc_pkg::word_type     word_in,
   output sha1bc_pkg::word_type     w_t
);
   import sha1bc_pkg::*;

   // sixteen-word window, entry 0 is the word for the current round
   word_type w_ff [WORDS_PER_BLOCK];
   word_type w_in [WORDS_PER_BLOCK];
   word_type expand_xor;
   word_type expand_word;

   // message expansion from the fixed taps of the window
   always_comb begin
      expand_xor  = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
      expand_word = {expand_xor[WORD_BITS-2:0], expand_xor[WORD_BITS-1]};
   end

   // shift the window by one, new word at the top
   always_comb begin
      for (int i = 0; i < WORDS_PER_BLOCK - 1; i++) begin
         w_in[i] = w_ff[i+1];
      end
      w_in[WORDS_PER_BLOCK-1] = ctrl.shift_in ? word_in : expand_word;
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift_in || ctrl.expand) begin
         w_ff <= w_in;
      end
   end

   assign w_t = w_ff[0];

endmodule

// ===== sv/sha1bc_round.sv =====
`timescale 1ns / 1ps

module sha1bc_round (
   input  logic                       clock,
   input  logic                       reset,
   input  sha1bc_pkg::round_ctrl_type ctrl,
   input  sha1bc_pkg::word_type       w_t,
   output sha1bc_pkg::rsp_type        chain
);
   import sha1bc_pkg::*;

   word_type chain_ff [CHAIN_WORDS];
   word_type chain_in [CHAIN_WORDS];
   word_type work_ff  [CHAIN_WORDS];
   word_type work_in  [CHAIN_WORDS];
   word_type f_val;
   word_type k_val;
   word_type t_val;
   word_type a_rot5;
   word_type b_rot30;

   // round function for the current phase
   always_comb begin
      unique case (ctrl.phase)
         PH_CH:     f_val = (work_ff[1] & work_ff[2]) | (~work_ff[1] & work_ff[3]);
         PH_MAJ:    f_val = (work_ff[1] & work_ff[2]) | (work_ff[1] & work_ff[3]) |
                            (work_ff[2] & work_ff[3]);
         PH_PAR_LO,
         PH_PAR_HI: f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         default:   f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
      endcase
      k_val = round_const(ctrl.phase);
   end

   // shared round adder
   always_comb begin
      a_rot5  = {work_ff[0][WORD_BITS-6:0], work_ff[0][WORD_BITS-1:WORD_BITS-5]};
      b_rot30 = {work_ff[1][1:0], work_ff[1][WORD_BITS-1:2]};
      t_val   = a_rot5 + f_val + work_ff[4] + k_val + w_t;
   end

   // working word next values
   always_comb begin
      if (ctrl.load_work) begin
         work_in = chain_ff;
      end else begin
         work_in[0] = t_val;
         work_in[1] = work_ff[0];
         work_in[2] = b_rot30;
         work_in[3] = work_ff[2];
         work_in[4] = work_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_work || ctrl.round_en) begin
         work_ff <= work_in;
      end
   end

   // chaining words: reload or feed-forward
   always_comb begin
      for (int i = 0; i < CHAIN_WORDS; i++) begin
         if (ctrl.load_init) begin
            chain_in[i] = INIT_VALUES[i];
         end else if (ctrl.feed_fwd) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end else begin
            chain_in[i] = chain_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= INIT_VALUES;
      end else begin
         chain_ff <= chain_in;
      end
   end

   assign chain.digest_a = chain_ff[0];
   assign chain.digest_b = chain_ff[1];
   assign chain.digest_c = chain_ff[2];
   assign chain.digest_d = chain_ff[3];
   assign chain.digest_e = chain_ff[4];

endmodule

// ===== sv/sha1_block_compress.sv =====
`timescale 1ns / 1ps

// channel   ports                   handshake
// -------   ---------------------   -----------------------------------------
// input     start, busy, req_item   item taken at an edge with start && !busy
// result    rsp_valid, rsp_item     strobe for one cycle, always taken
//
// words of a block are taken one per cycle while busy is low
// after the sixteenth word busy stays high through the 80 rounds on the
//   shared round adder and the feed-forward addition
// the digest strobes in the same cycle as busy drops
// reset loads the standard chaining values and clears the word position
// the result side cannot stall; the next item may be taken during the strobe

module sha1_block_compress (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  sha1bc_pkg::req_type req_item,
   output logic                rsp_valid,
   output sha1bc_pkg::rsp_type rsp_item
);
   import sha1bc_pkg::*;

   state_type       state_ff, state_in;
   pos_type         pos_ff, pos_in;
   round_count_type count_ff, count_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            accept;
   logic            last_word;
   round_ctrl_type  round_ctrl;
   sched_ctrl_type  sched_ctrl;
   word_type        w_t;

   assign busy      = (state_ff != ST_COLLECT);
   assign accept    = start && !busy;
   assign last_word = !req_item.start_message && (pos_ff == LAST_POS);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            if (accept && last_word) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (count_ff == LAST_ROUND) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            state_in = ST_COLLECT;
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      round_ctrl.load_init = 1'b0;
      round_ctrl.load_work = 1'b0;
      round_ctrl.round_en  = 1'b0;
      round_ctrl.feed_fwd  = 1'b0;
      round_ctrl.phase     = round_phase(count_ff);
      sched_ctrl.shift_in  = 1'b0;
      sched_ctrl.expand    = 1'b0;
      rsp_valid_in         = 1'b0;
      unique case (state_ff)
         ST_COLLECT: begin
            round_ctrl.load_init = accept && req_item.start_message;
            round_ctrl.load_work = accept && last_word;
            sched_ctrl.shift_in  = accept;
         end
         ST_ROUND: begin
            round_ctrl.round_en = 1'b1;
            sched_ctrl.expand   = 1'b1;
         end
         ST_FINAL: begin
            round_ctrl.feed_fwd = 1'b1;
            rsp_valid_in        = 1'b1;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // word position and round counter
   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         pos_in = (req_item.start_message ? '0 : pos_ff) + pos_type'(1);
      end
      count_in = (state_ff == ST_ROUND) ? count_ff + round_count_type'(1) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         pos_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   sha1bc_schedule u_schedule (
      .clock   (clock),
      .ctrl    (sched_ctrl),
      .word_in (req_item.message_word),
      .w_t     (w_t)
   );

   sha1bc_round u_round (
      .clock (clock),
      .reset (reset),
      .ctrl  (round_ctrl),
      .w_t   (w_t),
      .chain (rsp_item)
   );

   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   // the digest strobes exactly after the feed-forward cycle
   a_strobe_after_final: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINAL) |=> rsp_valid)
      else $error("digest strobe missing after feed-forward");

   // a strobe only follows the feed-forward cycle
   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == ST_FINAL) && !busy)
      else $error("digest strobe without a finished block");

   // the word position is back at the block start while rounds run
   a_pos_in_rounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (pos_ff == '0))
      else $error("word position not cleared during rounds");

   // the last round leads to the feed-forward cycle
   a_round_limit: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_ROUND) && (count_ff == LAST_ROUND)) |=> (state_ff == ST_FINAL))
      else $error("round count overran");
`endif

endmodule
